// ===== rtl/trapezoid_step_period_generator_macros.svh =====
// Assertion macros for the checker file tsp_checker.sv.
`ifndef TRAPEZOID_STEP_PERIOD_GENERATOR_MACROS_SVH
`define TRAPEZOID_STEP_PERIOD_GENERATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define TSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trapezoid step period check failed");

// Next-cycle implication, ignored while reset is held.
`define TSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trapezoid step period check failed");

// Next-cycle implication that also holds across reset.
`define TSP_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("trapezoid step period reset check failed");

`endif

// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  localparam int COUNT_BITS_DEF = 24;

  localparam int SPEED_BITS = 18;
  localparam int ACCEL_BITS = 19;
  localparam int PW_BITS    = 8;
  localparam int LOW_BITS   = 15;
  localparam int PHASE_BITS = 2;
  localparam int A2_BITS    = ACCEL_BITS + 1;
  localparam int RAMP_BITS  = 2 * SPEED_BITS;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 19;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEED   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_WIDTH = 2'd2;

  localparam logic [SPEED_BITS-1:0] MAX_SPEED_RST = 18'd142000;
  localparam logic [ACCEL_BITS-1:0] ACCEL_RST     = 19'd102000;
  localparam logic [PW_BITS-1:0]    PW_RST        = 8'd5;

  localparam logic [PHASE_BITS-1:0] PHASE_ACCEL  = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_CRUISE = 2'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_DECEL  = 2'd2;

  localparam logic [LOW_BITS-1:0] FINAL_LOW_US = 15'd10;
  localparam logic [31:0]         MIN_SPEED_Q8 = 32'd12800;
  localparam logic [63:0]         RAD_CAP      = 64'h0000_8000_0000_0000;

  localparam int SQRT_ITERS     = 32;
  localparam int SQRT_PER_STAGE = 4;
  localparam int SQRT_STAGES    = SQRT_ITERS / SQRT_PER_STAGE;

  localparam int DIV_ITERS     = LOW_BITS;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = DIV_ITERS / DIV_PER_STAGE;

  localparam logic [27:0]          US_SCALE_Q8  = 28'd256000000;
  localparam logic [32:0]          DIV_REM_INIT = 33'(US_SCALE_Q8 >> DIV_ITERS);
  localparam logic [DIV_ITERS-1:0] DIV_LOW_BITS = US_SCALE_Q8[DIV_ITERS-1:0];

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic                  final_step;
    logic                  index_error;
    logic                  use_peak;
  } side_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DIV  = 3'b100
  } cfg_state_t;

endpackage

`default_nettype wire

// ===== rtl/trapezoid_step_period_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake           Payload
// in       in_valid/in_stall   in_step_index, in_total_steps
// out      out_valid/out_stall out_high_us, out_low_us, out_phase, out_final_step,
//                              out_index_error
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction per cycle is accepted while in_stall is low; each result is registered.
// The pipe is 4 decode/multiply stages, square root stages (4 root bits each)
// and divider stages (3 quotient bits each), then the output register.
// After reset and after every configuration write the ramp length is rebuilt by a
// serial divider, and in_stall is held high until it is done.
// A stalled output freezes the whole pipe, so nothing is lost or repeated.

module trapezoid_step_period_generator #(
  parameter int STEP_COUNT_BITS = tsp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [STEP_COUNT_BITS-1:0]         in_step_index,
  input  wire logic [STEP_COUNT_BITS-1:0]         in_total_steps,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [tsp_pkg::PW_BITS-1:0]             out_high_us,
  output logic [tsp_pkg::LOW_BITS-1:0]            out_low_us,
  output logic [tsp_pkg::PHASE_BITS-1:0]          out_phase,
  output logic                                    out_final_step,
  output logic                                    out_index_error,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tsp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tsp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CB        = STEP_COUNT_BITS;
  localparam int PROD_BITS = tsp_pkg::A2_BITS + CB;
  localparam int SQS       = tsp_pkg::SQRT_STAGES;
  localparam int DVS       = tsp_pkg::DIV_STAGES;

  // Configuration registers.
  logic [tsp_pkg::SPEED_BITS-1:0] max_speed_r;
  logic [tsp_pkg::ACCEL_BITS-1:0] accel_r;
  logic [tsp_pkg::PW_BITS-1:0]    pw_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= tsp_pkg::MAX_SPEED_RST;
      accel_r     <= tsp_pkg::ACCEL_RST;
      pw_r        <= tsp_pkg::PW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsp_pkg::REG_MAX_SPEED:   max_speed_r <= cfg_data[tsp_pkg::SPEED_BITS-1:0];
        tsp_pkg::REG_ACCEL:       accel_r     <= cfg_data[tsp_pkg::ACCEL_BITS-1:0];
        tsp_pkg::REG_PULSE_WIDTH: pw_r        <= cfg_data[tsp_pkg::PW_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [tsp_pkg::ACCEL_BITS-1:0] a_eff;
  logic [tsp_pkg::A2_BITS-1:0]    a2;
  assign a_eff = (accel_r == '0) ? tsp_pkg::ACCEL_BITS'(1) : accel_r;
  assign a2    = {a_eff, 1'b0};

  // Ramp length max_speed^2 / (2a), one quotient bit per cycle.
  tsp_pkg::cfg_state_t            state_r;
  logic [tsp_pkg::RAMP_BITS-1:0]  rq_r;
  logic [tsp_pkg::A2_BITS-1:0]    rden_r;
  logic [tsp_pkg::A2_BITS-1:0]    rrem_r;
  logic [5:0]                     rcnt_r;
  logic [tsp_pkg::A2_BITS:0]      rrem_sh;
  logic                           rge;
  logic [tsp_pkg::A2_BITS-1:0]    rrem_nxt;

  assign rrem_sh  = {rrem_r, rq_r[tsp_pkg::RAMP_BITS-1]};
  assign rge      = rrem_sh >= {1'b0, rden_r};
  assign rrem_nxt = rge ? tsp_pkg::A2_BITS'(rrem_sh - {1'b0, rden_r})
                        : rrem_sh[tsp_pkg::A2_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsp_pkg::ST_MUL;
    end else if (cfg_valid) begin
      state_r <= tsp_pkg::ST_MUL;
    end else begin
      unique case (state_r)
        tsp_pkg::ST_MUL: state_r <= tsp_pkg::ST_DIV;
        tsp_pkg::ST_DIV: if (rcnt_r == '0) state_r <= tsp_pkg::ST_IDLE;
        tsp_pkg::ST_IDLE: state_r <= tsp_pkg::ST_IDLE;
        default: state_r <= tsp_pkg::ST_MUL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tsp_pkg::ST_MUL) begin
      rq_r   <= tsp_pkg::RAMP_BITS'(max_speed_r * max_speed_r);
      rden_r <= a2;
      rrem_r <= '0;
      rcnt_r <= 6'(tsp_pkg::RAMP_BITS - 1);
    end else if (state_r == tsp_pkg::ST_DIV) begin
      // The dividend shifts out at the top while quotient bits shift in.
      rq_r   <= {rq_r[tsp_pkg::RAMP_BITS-2:0], rge};
      rrem_r <= rrem_nxt;
      rcnt_r <= rcnt_r - 6'd1;
    end
  end

  // Pipeline control.
  logic out_valid_r;
  logic adv;
  logic busy;
  logic accept;

  assign busy     = state_r != tsp_pkg::ST_IDLE;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = busy || !adv;
  assign accept   = in_valid && !in_stall;

  // Stage 1: input register.
  logic          p1_v_r;
  logic [CB-1:0] p1_idx_r, p1_tot_r;

  // Stage 2: error, final step and effective ramp.
  logic          p2_v_r;
  logic [CB-1:0] p2_idx_r, p2_tot_r, p2_ramp_r;
  logic          p2_halved_r, p2_err_r, p2_fin_r;
  logic          p2_err_nxt, p2_fin_nxt, p2_halved_nxt;
  logic [CB-1:0] p2_ramp_nxt;

  assign p2_err_nxt    = p1_idx_r >= p1_tot_r;
  assign p2_fin_nxt    = !p2_err_nxt && (({1'b0, p1_idx_r} + (CB+1)'(1)) == {1'b0, p1_tot_r});
  assign p2_halved_nxt = {rq_r, 1'b0} > (tsp_pkg::RAMP_BITS+1)'(p1_tot_r);
  assign p2_ramp_nxt   = p2_halved_nxt ? (p1_tot_r >> 1) : rq_r[CB-1:0];

  // Stage 3: segment and ramp step count.
  logic          p3_v_r;
  tsp_pkg::side_t p3_side_r, p3_side_nxt;
  logic [CB-1:0] p3_n_r, p3_n_nxt;

  always_comb begin
    p3_side_nxt.final_step  = p2_fin_r;
    p3_side_nxt.index_error = p2_err_r;
    p3_side_nxt.use_peak    = 1'b0;
    if (p2_err_r) begin
      p3_side_nxt.phase = tsp_pkg::PHASE_DECEL;
      p3_n_nxt          = '0;
    end else if (p2_idx_r < p2_ramp_r) begin
      p3_side_nxt.phase = tsp_pkg::PHASE_ACCEL;
      p3_n_nxt          = p2_idx_r + CB'(1);
    end else if (p2_idx_r < (p2_tot_r - p2_ramp_r)) begin
      // Cruise runs at max_speed unless the ramps were shortened.
      p3_side_nxt.phase    = tsp_pkg::PHASE_CRUISE;
      p3_side_nxt.use_peak = !p2_halved_r;
      p3_n_nxt             = p2_ramp_r;
    end else begin
      p3_side_nxt.phase = tsp_pkg::PHASE_DECEL;
      p3_n_nxt          = p2_tot_r - p2_idx_r;
    end
  end

  // Stage 4: radicand product 2a*n.
  logic                 p4_v_r;
  tsp_pkg::side_t       p4_side_r;
  logic [PROD_BITS-1:0] p4_prod_r;
  logic [63:0]          p4_prod_ext;
  logic [47:0]          rad_clamped;

  assign p4_prod_ext = 64'(p4_prod_r);
  assign rad_clamped = (p4_prod_ext > tsp_pkg::RAD_CAP) ? tsp_pkg::RAD_CAP[47:0]
                                                        : p4_prod_ext[47:0];

  // Square root stages: radicand bits leave at the top two at a time.
  logic           sq_v_r    [0:SQS];
  tsp_pkg::side_t sq_side_r [0:SQS];
  logic [63:0]    sq_x_r    [0:SQS];
  logic [33:0]    sq_rem_r  [0:SQS];
  logic [31:0]    sq_root_r [0:SQS];
  logic [63:0]    sq_x_nxt    [1:SQS];
  logic [33:0]    sq_rem_nxt  [1:SQS];
  logic [31:0]    sq_root_nxt [1:SQS];

  always_comb begin
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
    logic [35:0] rs;
    logic [35:0] t;
    for (int k = 0; k < SQS; k++) begin
      x    = sq_x_r[k];
      rem  = sq_rem_r[k];
      root = sq_root_r[k];
      for (int j = 0; j < tsp_pkg::SQRT_PER_STAGE; j++) begin
        rs = {rem, x[63:62]};
        t  = {2'b00, root, 2'b01};
        if (rs >= t) begin
          rem  = 34'(rs - t);
          root = {root[30:0], 1'b1};
        end else begin
          rem  = rs[33:0];
          root = {root[30:0], 1'b0};
        end
        x = {x[61:0], 2'b00};
      end
      sq_x_nxt[k+1]    = x;
      sq_rem_nxt[k+1]  = rem;
      sq_root_nxt[k+1] = root;
    end
  end

  // Divider stages: 256e6 / speed, restoring, dividend bits are constants.
  logic           dv_v_r    [0:DVS];
  tsp_pkg::side_t dv_side_r [0:DVS];
  logic [31:0]    dv_s_r    [0:DVS];
  logic [32:0]    dv_rem_r  [0:DVS];
  logic [tsp_pkg::LOW_BITS-1:0] dv_q_r   [0:DVS];
  logic [32:0]                  dv_rem_nxt [1:DVS];
  logic [tsp_pkg::LOW_BITS-1:0] dv_q_nxt   [1:DVS];
  logic [31:0]    speed_raw, speed_nxt;

  assign speed_raw = sq_side_r[SQS].use_peak ? 32'({max_speed_r, 8'h00}) : sq_root_r[SQS];
  assign speed_nxt = (speed_raw < tsp_pkg::MIN_SPEED_Q8) ? tsp_pkg::MIN_SPEED_Q8 : speed_raw;

  always_comb begin
    logic [32:0] rem;
    logic [32:0] rs;
    logic [tsp_pkg::LOW_BITS-1:0] q;
    int b;
    for (int k = 0; k < DVS; k++) begin
      rem = dv_rem_r[k];
      q   = dv_q_r[k];
      for (int j = 0; j < tsp_pkg::DIV_PER_STAGE; j++) begin
        b  = tsp_pkg::DIV_ITERS - 1 - (k * tsp_pkg::DIV_PER_STAGE + j);
        rs = {rem[31:0], tsp_pkg::DIV_LOW_BITS[b]};
        if (rs >= {1'b0, dv_s_r[k]}) begin
          rem = rs - {1'b0, dv_s_r[k]};
          q   = {q[tsp_pkg::LOW_BITS-2:0], 1'b1};
        end else begin
          rem = rs;
          q   = {q[tsp_pkg::LOW_BITS-2:0], 1'b0};
        end
      end
      dv_rem_nxt[k+1] = rem;
      dv_q_nxt[k+1]   = q;
    end
  end

  // Output stage: period floor, pulse width removal, final step.
  logic [tsp_pkg::LOW_BITS-1:0] period;
  logic [tsp_pkg::LOW_BITS-1:0] pw_ext;
  logic [tsp_pkg::LOW_BITS-1:0] low_nxt;

  assign pw_ext = tsp_pkg::LOW_BITS'(pw_r);

  always_comb begin
    period = dv_q_r[DVS];
    if (period <= pw_ext) period = pw_ext + tsp_pkg::LOW_BITS'(1);
    low_nxt = period - pw_ext;
    if (dv_side_r[DVS].final_step) low_nxt = tsp_pkg::FINAL_LOW_US;
  end

  logic [tsp_pkg::PW_BITS-1:0]    out_high_r;
  logic [tsp_pkg::LOW_BITS-1:0]   out_low_r;
  logic [tsp_pkg::PHASE_BITS-1:0] out_phase_r;
  logic                           out_final_r, out_err_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= SQS; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k <= DVS; k++) dv_v_r[k] <= 1'b0;
    end else if (adv) begin
      p1_v_r    <= accept;
      p2_v_r    <= p1_v_r;
      p3_v_r    <= p2_v_r;
      p4_v_r    <= p3_v_r;
      sq_v_r[0] <= p4_v_r;
      for (int k = 0; k < SQS; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[SQS];
      for (int k = 0; k < DVS; k++) dv_v_r[k+1] <= dv_v_r[k];
      out_valid_r <= dv_v_r[DVS];
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_idx_r <= in_step_index;
      p1_tot_r <= in_total_steps;

      p2_idx_r    <= p1_idx_r;
      p2_tot_r    <= p1_tot_r;
      p2_ramp_r   <= p2_ramp_nxt;
      p2_halved_r <= p2_halved_nxt;
      p2_err_r    <= p2_err_nxt;
      p2_fin_r    <= p2_fin_nxt;

      p3_side_r <= p3_side_nxt;
      p3_n_r    <= p3_n_nxt;

      p4_side_r <= p3_side_r;
      p4_prod_r <= PROD_BITS'(a2 * p3_n_r);

      sq_side_r[0] <= p4_side_r;
      sq_x_r[0]    <= {rad_clamped, 16'h0000};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      for (int k = 0; k < SQS; k++) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_x_r[k+1]    <= sq_x_nxt[k+1];
        sq_rem_r[k+1]  <= sq_rem_nxt[k+1];
        sq_root_r[k+1] <= sq_root_nxt[k+1];
      end

      dv_side_r[0] <= sq_side_r[SQS];
      dv_s_r[0]    <= speed_nxt;
      dv_rem_r[0]  <= tsp_pkg::DIV_REM_INIT;
      dv_q_r[0]    <= '0;
      for (int k = 0; k < DVS; k++) begin
        dv_side_r[k+1] <= dv_side_r[k];
        dv_s_r[k+1]    <= dv_s_r[k];
        dv_rem_r[k+1]  <= dv_rem_nxt[k+1];
        dv_q_r[k+1]    <= dv_q_nxt[k+1];
      end

      out_high_r  <= pw_r;
      out_low_r   <= low_nxt;
      out_phase_r <= dv_side_r[DVS].phase;
      out_final_r <= dv_side_r[DVS].final_step;
      out_err_r   <= dv_side_r[DVS].index_error;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_high_us     = out_high_r;
  assign out_low_us      = out_low_r;
  assign out_phase       = out_phase_r;
  assign out_final_step  = out_final_r;
  assign out_index_error = out_err_r;

endmodule

`default_nettype wire

// ===== rtl/tsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "trapezoid_step_period_generator_macros.svh"

module tsp_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [tsp_pkg::LOW_BITS-1:0]    out_low_us,
  input wire logic [tsp_pkg::PHASE_BITS-1:0]  out_phase,
  input wire logic                            out_final_step,
  input wire logic                            out_index_error
);

  `TSP_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_low_us) && $stable(out_phase))
  `TSP_ASSERT_NOW(a_err_decel, out_valid && out_index_error, (out_phase == tsp_pkg::PHASE_DECEL) && !out_final_step)
  `TSP_ASSERT_NOW(a_final_low, out_valid && out_final_step, (out_low_us == tsp_pkg::FINAL_LOW_US) && !out_index_error)
  `TSP_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind trapezoid_step_period_generator tsp_checker u_tsp_checker (.*);

`default_nettype wire
